### design/sfsa_pkg.sv
// shared types, constants and helpers of the spreading factor slot allocator
package sfsa_pkg;

	localparam int NUM_FACTORS = 6;
	localparam int IDX_W = $clog2(NUM_FACTORS + 1);
	localparam int HP_W = 24;
	localparam int POOL_W = 32;
	localparam int TOTAL_W = 25;
	localparam int SF_W = 4;
	localparam int SF_BASE = 7;
	localparam logic [HP_W-1:0] RESET_HP = 24'd16000;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_RELOAD = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_RELOAD,
		OP_ADD,
		OP_RELEASE
	} op_t;

	typedef struct packed {
		op_t op;
		logic [IDX_W-1:0] min_k;
		logic [IDX_W-1:0] max_k;
		logic [IDX_W-1:0] rel_k;
		logic [HP_W-1:0] need;
		logic [HP_W-1:0] hp;
	} pool_req_t;

	typedef struct packed {
		logic done;
		logic accepted;
		logic [SF_W-1:0] assigned_sf;
		logic [POOL_W-1:0] free_total;
		logic [TOTAL_W-1:0] pool_total;
	} pool_rsp_t;

	// lowest pool index the distance allows, NUM_FACTORS when out of range
	function automatic logic [IDX_W-1:0] min_index(input logic [15:0] d);
		logic [IDX_W-1:0] k;
		if (d < 16'd125) k = IDX_W'(0);
		else if (d < 16'd250) k = IDX_W'(1);
		else if (d < 16'd500) k = IDX_W'(2);
		else if (d < 16'd1000) k = IDX_W'(3);
		else if (d < 16'd2000) k = IDX_W'(4);
		else if (d < 16'd4000) k = IDX_W'(5);
		else k = IDX_W'(NUM_FACTORS);
		return k;
	endfunction

	// highest pool index the period allows, valid only above 100
	function automatic logic [IDX_W-1:0] max_index(input logic [HP_W-1:0] p);
		logic [IDX_W-1:0] k;
		if (p > 24'd3200) k = IDX_W'(5);
		else if (p > 24'd1600) k = IDX_W'(4);
		else if (p > 24'd800) k = IDX_W'(3);
		else if (p > 24'd400) k = IDX_W'(2);
		else if (p > 24'd200) k = IDX_W'(1);
		else k = IDX_W'(0);
		return k;
	endfunction

	localparam logic [HP_W-1:0] MAX_P_FLOOR = 24'd100;

	function automatic logic [POOL_W-1:0] reset_pool(input int i);
		return POOL_W'(RESET_HP >> i);
	endfunction

	function automatic logic [TOTAL_W-1:0] reset_total();
		logic [TOTAL_W-1:0] s;
		s = '0;
		for (int i = 0; i < NUM_FACTORS; i++) begin
			s = s + TOTAL_W'(RESET_HP >> i);
		end
		return s;
	endfunction

endpackage

### design/sfsa_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module sfsa_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [sfsa_pkg::HP_W-1:0] dividend,
	input  logic [sfsa_pkg::HP_W-1:0] divisor,
	output logic done,
	output logic [sfsa_pkg::HP_W-1:0] quotient
);

	localparam int W = sfsa_pkg::HP_W;
	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;

	logic [W:0] shifted;
	logic [W:0] trial;
	logic fits;

	assign shifted = {rem_q, quo_q[W-1]};
	assign trial = shifted - {1'b0, div_q};
	assign fits = ~trial[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? trial[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(run_q)) else $error("divider done without a run");
	a_no_done_while_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !run_q) else $error("divider done while still running");
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (cnt_q != '0)) else $error("divider count ran out while busy");

endmodule

### design/sfsa_pool_bank.sv
// six slot pools in a rotating register line, one pool handled per cycle
module sfsa_pool_bank #(
	parameter int NUM_FACTORS = sfsa_pkg::NUM_FACTORS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  sfsa_pkg::pool_req_t req,
	output sfsa_pkg::pool_rsp_t rsp
);

	localparam int IW = sfsa_pkg::IDX_W;
	localparam int PW = sfsa_pkg::POOL_W;
	localparam int HW = sfsa_pkg::HP_W;
	localparam int TW = sfsa_pkg::TOTAL_W;
	localparam int SW = sfsa_pkg::SF_W;
	localparam int AW = PW + 3;

	logic [PW-1:0] pool_q [NUM_FACTORS];
	logic [TW-1:0] total_q;
	logic [IW-1:0] idx_q;
	logic active_q;
	logic found_q;
	logic [SW-1:0] granted_q;
	logic [AW-1:0] acc_q;
	logic [TW-1:0] tot_acc_q;
	logic [HW-1:0] hp_sh_q;
	logic done_q;
	logic accepted_q;
	logic [SW-1:0] assigned_q;
	logic [PW-1:0] free_q;

	logic [PW-1:0] head;
	logic [PW-1:0] upd;
	logic [PW:0] rel_sum;
	logic hit_add;
	logic hit_rel;
	logic last;
	logic [AW-1:0] acc_next;
	logic [TW-1:0] tot_next;

	assign head = pool_q[0];
	assign last = (idx_q == IW'(NUM_FACTORS - 1));
	assign hit_add = (req.op == sfsa_pkg::OP_ADD) && !found_q && (idx_q >= req.min_k)
		&& (idx_q <= req.max_k) && (head >= {{(PW-HW){1'b0}}, req.need});
	assign hit_rel = (req.op == sfsa_pkg::OP_RELEASE) && (idx_q == req.rel_k);
	assign rel_sum = {1'b0, head} + {{(PW-HW+1){1'b0}}, req.need};
	assign tot_next = tot_acc_q + {{(TW-HW){1'b0}}, hp_sh_q};

	always_comb begin
		upd = head;
		case (req.op)
			sfsa_pkg::OP_RELOAD: upd = {{(PW-HW){1'b0}}, hp_sh_q};
			sfsa_pkg::OP_ADD: begin
				if (hit_add) upd = head - {{(PW-HW){1'b0}}, req.need};
			end
			sfsa_pkg::OP_RELEASE: begin
				// saturate at the top of the pool
				if (hit_rel) upd = rel_sum[PW] ? '1 : rel_sum[PW-1:0];
			end
			default: upd = head;
		endcase
	end

	assign acc_next = acc_q + {3'b000, upd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FACTORS; i++) begin
				pool_q[i] <= sfsa_pkg::reset_pool(i);
			end
			total_q <= sfsa_pkg::reset_total();
			active_q <= 1'b0;
			done_q <= 1'b0;
			idx_q <= '0;
			found_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				active_q <= 1'b1;
				idx_q <= '0;
				found_q <= 1'b0;
			end else if (active_q) begin
				// rotate: after the last pool the line is back in order
				for (int i = 0; i < NUM_FACTORS - 1; i++) begin
					pool_q[i] <= pool_q[i+1];
				end
				pool_q[NUM_FACTORS-1] <= upd;
				idx_q <= idx_q + IW'(1);
				if (hit_add || hit_rel) found_q <= 1'b1;
				if (last) begin
					active_q <= 1'b0;
					done_q <= 1'b1;
					if (req.op == sfsa_pkg::OP_RELOAD) total_q <= tot_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			tot_acc_q <= '0;
			hp_sh_q <= req.hp;
			granted_q <= '0;
		end else if (active_q) begin
			acc_q <= acc_next;
			tot_acc_q <= tot_next;
			hp_sh_q <= hp_sh_q >> 1;
			if (hit_add) granted_q <= SW'(sfsa_pkg::SF_BASE) + SW'(idx_q);
			if (last) begin
				accepted_q <= found_q || hit_add || hit_rel;
				assigned_q <= hit_add ? SW'(sfsa_pkg::SF_BASE) + SW'(idx_q) : granted_q;
				free_q <= (acc_next[AW-1:PW] != '0) ? '1 : acc_next[PW-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.accepted = accepted_q;
	assign rsp.assigned_sf = assigned_q;
	assign rsp.free_total = free_q;
	assign rsp.pool_total = total_q;

	a_done_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !active_q && $past(active_q)) else $error("done without a walk");
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q < IW'(NUM_FACTORS))) else $error("pool index out of range");
	a_single_grant: assert property (@(posedge clk) disable iff (!arst_n)
		hit_add && active_q |-> !found_q) else $error("second grant in one walk");

endmodule

### design/spreading_factor_slot_allocator.sv
// top level: command decode, slot demand divider and pool bank sequencing
// with a nonzero period, a 24-step bit-serial divide of hyperperiod by period
// runs first, followed by a walk over the six pools of the rotating pool line;
// a zero period goes straight to the walk
// busy stays high from accept until done; no new item is taken meanwhile
// reset: pools reload to 16000 >> index, hyperperiod to 16000, block idle
module spreading_factor_slot_allocator #(
	parameter int NUM_FACTORS = sfsa_pkg::NUM_FACTORS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] command,
	input  logic [15:0] distance_half_m,
	input  logic [sfsa_pkg::HP_W-1:0] period,
	input  logic [3:0] sf_in,
	input  logic hyperperiod_we,
	input  logic [sfsa_pkg::HP_W-1:0] hyperperiod_wdata,
	output logic done,
	output logic accepted,
	output logic [sfsa_pkg::SF_W-1:0] assigned_sf,
	output logic [sfsa_pkg::POOL_W-1:0] free_total,
	output logic [sfsa_pkg::TOTAL_W-1:0] pool_total
);

	localparam int IW = sfsa_pkg::IDX_W;
	localparam int HW = sfsa_pkg::HP_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_WAIT
	} state_t;

	state_t state_q;
	logic [HW-1:0] hp_q;
	logic div_start_q;
	logic pool_go_q;
	sfsa_pkg::op_t op_q;
	logic [IW-1:0] min_k_q;
	logic [IW-1:0] max_k_q;
	logic [IW-1:0] rel_k_q;
	logic [HW-1:0] need_q;
	logic [HW-1:0] period_q_hold;

	logic accept;
	logic div_done;
	logic [HW-1:0] quotient;
	sfsa_pkg::op_t op_dec;
	sfsa_pkg::pool_req_t req;
	sfsa_pkg::pool_rsp_t rsp;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		op_dec = sfsa_pkg::OP_NONE;
		case (command)
			sfsa_pkg::CMD_ADD: begin
				if (period > sfsa_pkg::MAX_P_FLOOR) op_dec = sfsa_pkg::OP_ADD;
			end
			sfsa_pkg::CMD_RELEASE: begin
				if (sf_in >= 4'd7 && sf_in <= 4'd12 && period != '0)
					op_dec = sfsa_pkg::OP_RELEASE;
			end
			sfsa_pkg::CMD_RELOAD: op_dec = sfsa_pkg::OP_RELOAD;
			default: op_dec = sfsa_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hp_q <= sfsa_pkg::RESET_HP;
			div_start_q <= 1'b0;
			pool_go_q <= 1'b0;
		end else begin
			if (hyperperiod_we) hp_q <= hyperperiod_wdata;
			div_start_q <= 1'b0;
			pool_go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (period != '0) begin
							div_start_q <= 1'b1;
							state_q <= ST_DIV;
						end else begin
							pool_go_q <= 1'b1;
							state_q <= ST_WAIT;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						pool_go_q <= 1'b1;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (rsp.done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_dec;
			min_k_q <= sfsa_pkg::min_index(distance_half_m);
			max_k_q <= sfsa_pkg::max_index(period);
			rel_k_q <= IW'(sf_in - 4'd7);
			need_q <= '0;
		end else if (div_done) begin
			need_q <= quotient;
		end
	end

	assign req.op = op_q;
	assign req.min_k = min_k_q;
	assign req.max_k = max_k_q;
	assign req.rel_k = rel_k_q;
	assign req.need = need_q;
	assign req.hp = hp_q;

	sfsa_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start_q),
		.dividend(hp_q),
		.divisor(period_q_hold),
		.done(div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk) begin
		if (accept) period_q_hold <= period;
	end

	sfsa_pool_bank #(
		.NUM_FACTORS(NUM_FACTORS)
	) u_pools (
		.clk(clk),
		.arst_n(arst_n),
		.go(pool_go_q),
		.req(req),
		.rsp(rsp)
	);

	assign done = rsp.done;
	assign accepted = rsp.accepted;
	assign assigned_sf = rsp.assigned_sf;
	assign free_total = rsp.free_total;
	assign pool_total = rsp.pool_total;

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside an item");
	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("item taken but block not busy");
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && assigned_sf != '0 |-> accepted && assigned_sf >= 4'd7 && assigned_sf <= 4'd12)
		else $error("granted factor out of range");

endmodule

### tb/sv/sfsa_slot_checker.sv
`timescale 1ns / 100ps
// checker for the slot allocator: predicts every result and compares it with the block
module sfsa_slot_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic [1:0] command,
	input  logic [15:0] distance_half_m,
	input  logic [sfsa_pkg::HP_W-1:0] period,
	input  logic [3:0] sf_in,
	input  logic hyperperiod_we,
	input  logic [sfsa_pkg::HP_W-1:0] hyperperiod_wdata,
	input  logic done,
	input  logic accepted,
	input  logic [sfsa_pkg::SF_W-1:0] assigned_sf,
	input  logic [sfsa_pkg::POOL_W-1:0] free_total,
	input  logic [sfsa_pkg::TOTAL_W-1:0] pool_total,
	output int fail_count,
	output int pending,
	output int grant_count
);

	localparam int HW = sfsa_pkg::HP_W;
	localparam int SW = sfsa_pkg::SF_W;
	localparam int PW = sfsa_pkg::POOL_W;
	localparam int TW = sfsa_pkg::TOTAL_W;
	localparam int NF = sfsa_pkg::NUM_FACTORS;
	localparam int SB = sfsa_pkg::SF_BASE;

	typedef struct packed {
		logic accepted;
		logic [SW-1:0] sf;
		logic [PW-1:0] free;
		logic [TW-1:0] total;
	} slot_result_t;

	slot_result_t expected_results[$];
	slot_result_t want;
	logic [PW-1:0] pool_level [NF];
	logic [TW-1:0] reload_sum;
	logic [HW-1:0] hp_now;
	int mismatches;
	int grants;

	function automatic void refill_pools();
		logic [TW-1:0] s;
		s = '0;
		for (int i = 0; i < NF; i++) begin
			pool_level[i] = PW'(hp_now >> i);
			s = s + TW'(hp_now >> i);
		end
		reload_sum = s;
	endfunction

	// applies one item to the pools and returns what the block should report
	function automatic slot_result_t predict_slots(input logic [1:0] cmd,
			input logic [15:0] d, input logic [HW-1:0] p, input logic [3:0] sf);
		slot_result_t r;
		int lo;
		int hi;
		int k;
		logic [HW-1:0] demand;
		logic [PW:0] grown;
		logic [PW+2:0] sum;
		r = '0;
		case (cmd)
		sfsa_pkg::CMD_ADD: begin
			if (d < 16'd125) lo = 0;
			else if (d < 16'd250) lo = 1;
			else if (d < 16'd500) lo = 2;
			else if (d < 16'd1000) lo = 3;
			else if (d < 16'd2000) lo = 4;
			else if (d < 16'd4000) lo = 5;
			else lo = NF;
			// -1 means the period is too short for any factor
			if (p > 24'd3200) hi = 5;
			else if (p > 24'd1600) hi = 4;
			else if (p > 24'd800) hi = 3;
			else if (p > 24'd400) hi = 2;
			else if (p > 24'd200) hi = 1;
			else if (p > 24'd100) hi = 0;
			else hi = -1;
			if (hi >= 0) begin
				demand = hp_now / p;
				for (int j = lo; j <= hi; j++) begin
					if (!r.accepted && pool_level[j] >= PW'(demand)) begin
						pool_level[j] = pool_level[j] - PW'(demand);
						r.accepted = 1'b1;
						r.sf = SW'(SB + j);
					end
				end
			end
		end
		sfsa_pkg::CMD_RELEASE: begin
			if (sf >= SB && sf <= SB + NF - 1 && p != '0) begin
				k = sf - SB;
				demand = hp_now / p;
				grown = {1'b0, pool_level[k]} + (PW+1)'(demand);
				pool_level[k] = grown[PW] ? '1 : grown[PW-1:0];
				r.accepted = 1'b1;
			end
		end
		sfsa_pkg::CMD_RELOAD: begin
			refill_pools();
		end
		default: begin
		end
		endcase
		sum = '0;
		for (int j = 0; j < NF; j++) begin
			sum = sum + (PW+3)'(pool_level[j]);
		end
		r.free = (sum > (PW+3)'({PW{1'b1}})) ? '1 : sum[PW-1:0];
		r.total = reload_sum;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_now = sfsa_pkg::RESET_HP;
			refill_pools();
			expected_results.delete();
			mismatches = 0;
			grants = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result strobe with no item outstanding");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, accepted);
						mismatches++;
					end
					if (assigned_sf !== want.sf) begin
						$error("assigned_sf: expected %0d, got %0d", want.sf, assigned_sf);
						mismatches++;
					end
					if (free_total !== want.free) begin
						$error("free_total: expected %0d, got %0d", want.free, free_total);
						mismatches++;
					end
					if (pool_total !== want.total) begin
						$error("pool_total: expected %0d, got %0d", want.total, pool_total);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				want = predict_slots(command, distance_half_m, period, sf_in);
				if (command == sfsa_pkg::CMD_ADD && want.accepted) grants++;
				expected_results = {expected_results, want};
			end
			// new hyperperiod takes effect from the next item on
			if (hyperperiod_we) hp_now = hyperperiod_wdata;
		end
		fail_count <= mismatches;
		pending <= expected_results.size();
		grant_count <= grants;
	end

endmodule

### tb/sv/spreading_factor_slot_allocator_tb.sv
`timescale 1ns / 100ps
// testbench top for the slot allocator: stimulus, hyperperiod writes, watchdog and verdict
module spreading_factor_slot_allocator_tb;

	localparam int HW = sfsa_pkg::HP_W;
	localparam int SW = sfsa_pkg::SF_W;
	localparam int PW = sfsa_pkg::POOL_W;
	localparam int TW = sfsa_pkg::TOTAL_W;
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam logic [HW-1:0] HP_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] command = '0;
	logic [15:0] distance_half_m = '0;
	logic [HW-1:0] period = '0;
	logic [3:0] sf_in = '0;
	logic hyperperiod_we = 1'b0;
	logic [HW-1:0] hyperperiod_wdata = '0;
	logic done;
	logic accepted;
	logic [SW-1:0] assigned_sf;
	logic [PW-1:0] free_total;
	logic [TW-1:0] pool_total;

	int fail_count;
	int pending;
	int grant_count;
	int stall_cycles = 0;
	int cmd_count [4] = '{0, 0, 0, 0};
	int hp_writes = 0;
	bit quiet = 1'b0;
	bit sending = 1'b0;

	spreading_factor_slot_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.distance_half_m(distance_half_m),
		.period(period),
		.sf_in(sf_in),
		.hyperperiod_we(hyperperiod_we),
		.hyperperiod_wdata(hyperperiod_wdata),
		.done(done),
		.accepted(accepted),
		.assigned_sf(assigned_sf),
		.free_total(free_total),
		.pool_total(pool_total)
	);

	sfsa_slot_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.distance_half_m(distance_half_m),
		.period(period),
		.sf_in(sf_in),
		.hyperperiod_we(hyperperiod_we),
		.hyperperiod_wdata(hyperperiod_wdata),
		.done(done),
		.accepted(accepted),
		.assigned_sf(assigned_sf),
		.free_total(free_total),
		.pool_total(pool_total),
		.fail_count(fail_count),
		.pending(pending),
		.grant_count(grant_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ends the run when neither an item nor a result moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic release_start();
		if (sending) begin
			start <= 1'b0;
			sending = 1'b0;
		end
	endtask

	// offers one item, waits for its accept, then maybe idles a burst
	task automatic send(input logic [1:0] cmd, input logic [15:0] d,
			input logic [HW-1:0] p, input logic [3:0] sf);
		start <= 1'b1;
		sending = 1'b1;
		command <= cmd;
		distance_half_m <= d;
		period <= p;
		sf_in <= sf;
		cmd_count[cmd]++;
		do @(posedge clk); while (busy);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			release_start();
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain();
		release_start();
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	task automatic set_hyperperiod(input logic [HW-1:0] v);
		drain();
		hyperperiod_we <= 1'b1;
		hyperperiod_wdata <= v;
		@(posedge clk);
		hyperperiod_we <= 1'b0;
		hp_writes++;
	endtask

	task automatic random_phase(input logic [HW-1:0] hp, input int n);
		int r;
		logic [15:0] d;
		logic [HW-1:0] p;
		logic [3:0] sf;
		set_hyperperiod(hp);
		send(sfsa_pkg::CMD_RELOAD, '0, '0, '0);
		repeat (n) begin
			r = $urandom_range(0, 99);
			d = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3999));
			case ($urandom_range(0, 9))
			0: p = HW'($urandom);
			1: p = HW'($urandom_range(0, 100));
			default: p = HW'($urandom_range(101, 6000));
			endcase
			sf = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(7, 12));
			if (r < 55) send(sfsa_pkg::CMD_ADD, d, p, sf);
			else if (r < 80) send(sfsa_pkg::CMD_RELEASE, d, p, sf);
			else if (r < 92) send(sfsa_pkg::CMD_RELOAD, d, p, sf);
			else send(CMD_NOP, d, p, sf);
			if ($urandom_range(0, 59) == 0) drain();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at the reset hyperperiod: threshold edges and odd cases
		send(sfsa_pkg::CMD_ADD, 16'd0, 24'd101, 4'd0);
		send(sfsa_pkg::CMD_ADD, 16'd124, 24'd100, 4'd0);
		send(sfsa_pkg::CMD_ADD, 16'd125, HP_MAX, 4'd0);
		send(sfsa_pkg::CMD_ADD, 16'd3999, 24'd3201, 4'd0);
		send(sfsa_pkg::CMD_ADD, 16'd4000, 24'd5000, 4'd0);
		send(sfsa_pkg::CMD_ADD, 16'hFFFF, 24'd0, 4'd0);
		send(sfsa_pkg::CMD_ADD, 16'd2000, 24'd1601, 4'd0);
		send(sfsa_pkg::CMD_ADD, 16'd1999, 24'd1600, 4'd0);
		send(sfsa_pkg::CMD_ADD, 16'd500, 24'd801, 4'hF);
		send(sfsa_pkg::CMD_ADD, 16'd999, 24'd401, 4'd0);
		send(sfsa_pkg::CMD_ADD, 16'd250, 24'd201, 4'd0);
		send(sfsa_pkg::CMD_ADD, 16'd249, 24'd200, 4'd0);
		send(sfsa_pkg::CMD_RELEASE, 16'd0, 24'd1000, 4'd7);
		send(sfsa_pkg::CMD_RELEASE, 16'd0, 24'd16000, 4'd12);
		send(sfsa_pkg::CMD_RELEASE, 16'd0, 24'd5, 4'd6);
		send(sfsa_pkg::CMD_RELEASE, 16'd0, 24'd5, 4'd13);
		send(sfsa_pkg::CMD_RELEASE, 16'hFFFF, HP_MAX, 4'hF);
		send(sfsa_pkg::CMD_RELEASE, 16'd0, 24'd0, 4'd9);
		send(sfsa_pkg::CMD_RELEASE, 16'd0, 24'd1, 4'd0);
		send(sfsa_pkg::CMD_RELOAD, 16'hFFFF, HP_MAX, 4'hF);
		send(CMD_NOP, 16'hFFFF, HP_MAX, 4'hF);
		send(CMD_NOP, 16'd0, 24'd0, 4'd0);

		// largest hyperperiod: push pools and the free sum into saturation
		set_hyperperiod(HP_MAX);
		send(sfsa_pkg::CMD_RELOAD, '0, '0, '0);
		repeat (265) send(sfsa_pkg::CMD_RELEASE, 16'($urandom), 24'd1, 4'd7);
		repeat (10) send(sfsa_pkg::CMD_RELEASE, 16'($urandom), 24'd1,
				4'($urandom_range(8, 12)));
		repeat (5) send(sfsa_pkg::CMD_ADD, 16'd0, HP_MAX, 4'd0);

		// mid distances with long periods: empty pool 4, then fall back to 5
		set_hyperperiod(sfsa_pkg::RESET_HP);
		send(sfsa_pkg::CMD_RELOAD, '0, '0, '0);
		repeat (320) send(sfsa_pkg::CMD_ADD, 16'($urandom_range(1000, 1999)),
				HW'($urandom_range(3201, 3400)), 4'd0);

		random_phase(sfsa_pkg::RESET_HP, 140);
		random_phase(24'd1, 140);
		random_phase(HW'($urandom_range(2, HP_MAX - 1)), 140);
		random_phase(HP_MAX, 140);
		quiet = 1'b1;
		random_phase(24'd300, 140);

		drain();
		repeat (40) @(posedge clk);
		$display("run covered %0d items: %0d add (%0d granted), %0d release,",
				cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
				cmd_count[sfsa_pkg::CMD_ADD], grant_count, cmd_count[sfsa_pkg::CMD_RELEASE]);
		$display("%0d reload, %0d unused code, %0d hyperperiod writes; pools saturated and emptied",
				cmd_count[sfsa_pkg::CMD_RELOAD], cmd_count[CMD_NOP], hp_writes);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
